>>> hw/rtl/telnet_negotiation_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// telnet_negotiation_filter_unit_macros.svh
// Assertion macros shared by the TELNET negotiation filter RTL.
// ----------------------------------------------------------------------------
`ifndef TELNET_NEGOTIATION_FILTER_UNIT_MACROS_SVH
`define TELNET_NEGOTIATION_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is high.
`define TNF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, also checked during reset.
`define TNF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TNF_ASSERT(lbl, clk, rst, prop, msg)
`define TNF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/tnf_pkg.sv
// ----------------------------------------------------------------------------
// tnf_pkg
// Types and protocol codes for the TELNET negotiation filter.
// ----------------------------------------------------------------------------
package tnf_pkg;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REFUSE = 1'b1;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_IAC    = 3'd1,
    PH_OPTION = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] value_byte;
    logic       refuse_with_dont;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } parse_res_t;

endpackage

>>> hw/rtl/tnf_in_if.sv
// ----------------------------------------------------------------------------
// tnf_in_if
// Request channel carrying received TELNET bytes.
// ----------------------------------------------------------------------------
interface tnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/tnf_out_if.sv
// ----------------------------------------------------------------------------
// tnf_out_if
// Result channel: display bytes and option refusals.
// ----------------------------------------------------------------------------
interface tnf_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] value_byte;
  logic       refuse_with_dont;

  modport source (output valid, output result_kind, output value_byte,
                  output refuse_with_dont, input ready);
  modport sink (input valid, input result_kind, input value_byte,
                input refuse_with_dont, output ready);
endinterface

>>> hw/rtl/telnet_negotiation_filter_unit.sv
// ----------------------------------------------------------------------------
// telnet_negotiation_filter_unit
// TELNET receive filter: passes data, refuses options, drops subnegotiation.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while ready is high. The parser phase
// register and the result decode settle within the accepting cycle; any result
// is registered at the accepting edge, into the output register (offered on the
// result port from the next cycle) when that is free or being taken, else into
// a second result slot behind it, which lets input keep flowing while a result
// waits; ready drops only when both slots hold results, so the sustained rate
// is one byte per cycle whenever the result side keeps taking. Bytes that give
// no result (IAC prefixes, dropped commands, subnegotiation) are still taken.
`include "telnet_negotiation_filter_unit_macros.svh"

module telnet_negotiation_filter_unit (
  input  logic clk,
  input  logic rst,
  tnf_in_if.sink    rx_chan,
  tnf_out_if.source res_chan
);
  import tnf_pkg::*;

  parse_res_t pres;
  logic       fire;
  logic       push;
  logic       pop;

  logic       out_valid;
  logic       out_valid_next;
  result_t    out_data;
  result_t    out_data_next;
  logic       skid_valid;
  logic       skid_valid_next;
  result_t    skid_data;
  result_t    skid_data_next;

  assign rx_chan.ready = ~skid_valid;
  assign fire          = rx_chan.valid & ~skid_valid;
  assign push          = fire & pres.valid;
  assign pop           = out_valid & res_chan.ready;

  tnf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_chan.rx_byte),
    .res     (pres)
  );

  always_comb begin
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    skid_valid_next = skid_valid;
    skid_data_next  = skid_data;
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_data_next   = skid_data;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = push;
        out_data_next  = pres.data;
      end
    end else if (push) begin
      skid_valid_next = 1'b1;
      skid_data_next  = pres.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
    out_data  <= out_data_next;
    skid_data <= skid_data_next;
  end

  assign res_chan.valid            = out_valid;
  assign res_chan.result_kind      = out_data.result_kind;
  assign res_chan.value_byte       = out_data.value_byte;
  assign res_chan.refuse_with_dont = out_data.refuse_with_dont;

  `TNF_ASSERT(a_skid_behind_out, clk, rst,
    skid_valid |-> out_valid,
    "second slot full while output register empty")
  `TNF_ASSERT(a_push_lands, clk, rst,
    push |=> out_valid,
    "accepted result not held")
  `TNF_ASSERT(a_data_no_dont, clk, rst,
    out_valid && out_data.result_kind == KIND_DATA |-> !out_data.refuse_with_dont,
    "data byte carries refusal flag")
  `TNF_ASSERT(a_skid_fill, clk, rst,
    push && out_valid && !res_chan.ready |=> skid_valid,
    "result dropped while output stalled")

endmodule

>>> hw/rtl/tnf_parser.sv
// ----------------------------------------------------------------------------
// tnf_parser
// IAC command parser: phase register plus per-byte result decode.
// ----------------------------------------------------------------------------
`include "telnet_negotiation_filter_unit_macros.svh"

module tnf_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output tnf_pkg::parse_res_t res
);
  import tnf_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   pending_was_do;
  logic   pending_was_do_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NORMAL;
      pending_was_do <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      pending_was_do <= pending_was_do_next;
    end
  end

  // next state
  always_comb begin
    phase_next          = PH_NORMAL;
    pending_was_do_next = pending_was_do;
    unique case (phase)
      PH_IAC: begin
        if (rx_byte == CODE_DO || rx_byte == CODE_DONT) begin
          phase_next          = PH_OPTION;
          pending_was_do_next = 1'b1;
        end else if (rx_byte == CODE_WILL || rx_byte == CODE_WONT) begin
          phase_next          = PH_OPTION;
          pending_was_do_next = 1'b0;
        end else if (rx_byte == CODE_SB) begin
          phase_next = PH_SUB;
        end else begin
          phase_next = PH_NORMAL;
        end
      end
      PH_OPTION: begin
        phase_next = PH_NORMAL;
      end
      PH_SUB: begin
        phase_next = (rx_byte == CODE_IAC) ? PH_SUBIAC : PH_SUB;
      end
      PH_SUBIAC: begin
        if (rx_byte == CODE_SE) begin
          phase_next = PH_NORMAL;
        end else if (rx_byte == CODE_IAC) begin
          phase_next = PH_SUBIAC;
        end else begin
          phase_next = PH_SUB;
        end
      end
      default: begin
        phase_next = (rx_byte == CODE_IAC) ? PH_IAC : PH_NORMAL;
      end
    endcase
  end

  // result decode
  always_comb begin
    res.valid                 = 1'b0;
    res.data.result_kind      = KIND_DATA;
    res.data.value_byte       = rx_byte;
    res.data.refuse_with_dont = 1'b0;
    unique case (phase) inside
      PH_IAC: begin
        res.valid = (rx_byte == CODE_IAC);
      end
      PH_OPTION: begin
        res.valid                 = 1'b1;
        res.data.result_kind      = KIND_REFUSE;
        res.data.refuse_with_dont = ~pending_was_do;
      end
      PH_SUB, PH_SUBIAC: begin
        res.valid = 1'b0;
      end
      default: begin
        res.valid = (rx_byte != CODE_IAC);
      end
    endcase
  end

  `TNF_ASSERT(a_iac_enters_cmd, clk, rst,
    fire && phase == PH_NORMAL && rx_byte == CODE_IAC |=> phase == PH_IAC,
    "IAC in data phase did not enter command phase")
  `TNF_ASSERT(a_option_refuses, clk, rst,
    fire && phase == PH_OPTION |-> res.valid && res.data.result_kind == KIND_REFUSE,
    "option byte produced no refusal")
  `TNF_ASSERT(a_refuse_only_option, clk, rst,
    res.valid && res.data.result_kind == KIND_REFUSE |-> phase == PH_OPTION,
    "refusal outside option phase")
  `TNF_ASSERT(a_sub_silent, clk, rst,
    phase == PH_SUB || phase == PH_SUBIAC |-> !res.valid,
    "result produced inside subnegotiation")

endmodule

>>> verif/tnf_stream_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tnf_stream_monitor
// Watches both channels of the TELNET filter, predicts and compares results.
// ----------------------------------------------------------------------------
// Every accepted request byte runs through a local copy of the parser. Any
// result that byte produces is queued, and each accepted result is compared
// field by field with the oldest queued entry. The count of mismatches and the
// number of entries still waiting go back to the top level.
module tnf_stream_monitor (
  input  logic clk,
  input  logic rst,
  tnf_in_if    rx_chan,
  tnf_out_if   res_chan,
  output int   mismatch_cnt,
  output int   expected_cnt
);
  import tnf_pkg::*;

  phase_t  phase_q;
  logic    pend_do_q;
  result_t expected_results[$];
  result_t got;
  result_t want;

  // Advances the parser by one byte; returns 1 when the byte yields a result.
  function automatic logic filter_step(input logic [7:0] b, output result_t r);
    logic hit;
    hit = 1'b0;
    r   = '0;
    case (phase_q)
      PH_IAC: begin
        if (b == CODE_IAC) begin
          phase_q       = PH_NORMAL;
          r.result_kind = KIND_DATA;
          r.value_byte  = CODE_IAC;
          hit           = 1'b1;
        end else if (b == CODE_DO || b == CODE_DONT) begin
          pend_do_q = 1'b1;
          phase_q   = PH_OPTION;
        end else if (b == CODE_WILL || b == CODE_WONT) begin
          pend_do_q = 1'b0;
          phase_q   = PH_OPTION;
        end else if (b == CODE_SB) begin
          phase_q = PH_SUB;
        end else begin
          phase_q = PH_NORMAL;
        end
      end
      PH_OPTION: begin
        phase_q            = PH_NORMAL;
        r.result_kind      = KIND_REFUSE;
        r.value_byte       = b;
        r.refuse_with_dont = !pend_do_q;
        hit                = 1'b1;
      end
      PH_SUB: begin
        if (b == CODE_IAC) phase_q = PH_SUBIAC;
      end
      PH_SUBIAC: begin
        if (b == CODE_SE) phase_q = PH_NORMAL;
        else if (b != CODE_IAC) phase_q = PH_SUB;
      end
      default: begin
        if (b == CODE_IAC) begin
          phase_q = PH_IAC;
        end else begin
          phase_q       = PH_NORMAL;
          r.result_kind = KIND_DATA;
          r.value_byte  = b;
          hit           = 1'b1;
        end
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase_q      = PH_NORMAL;
      pend_do_q    = 1'b0;
      mismatch_cnt = 0;
      expected_results.delete();
    end else begin
      if (rx_chan.valid && rx_chan.ready) begin
        if (filter_step(rx_chan.rx_byte, got)) expected_results.push_back(got);
      end
      if (res_chan.valid && res_chan.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: kind %0d value %02h dont %0d",
                 res_chan.result_kind, res_chan.value_byte, res_chan.refuse_with_dont);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (res_chan.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d",
                   want.result_kind, res_chan.result_kind);
            mismatch_cnt++;
          end
          if (res_chan.value_byte !== want.value_byte) begin
            $error("value_byte: expected %02h, actual %02h",
                   want.value_byte, res_chan.value_byte);
            mismatch_cnt++;
          end
          if (res_chan.refuse_with_dont !== want.refuse_with_dont) begin
            $error("refuse_with_dont: expected %0d, actual %0d",
                   want.refuse_with_dont, res_chan.refuse_with_dont);
            mismatch_cnt++;
          end
        end
      end
    end
    expected_cnt <= expected_results.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TELNET negotiation filter.
// ----------------------------------------------------------------------------
// Sends a short directed stream (data extremes, escaped IAC, all four option
// commands, a subnegotiation with IAC runs, unknown commands), then mostly
// well-formed random sequences mixed with noise. Both sides idle in random
// bursts; once the result side holds off long enough to stall the input.
// Checking is done by tnf_stream_monitor.
module tb_top;
  import tnf_pkg::*;

  localparam int NUM_REQUESTS   = 1050;
  localparam int QUIET_FROM     = 900;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  int   sent_cnt = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   stall_cycles = 0;
  int   mismatch_cnt;
  int   expected_cnt;
  bit   hold_done = 1'b0;

  tnf_in_if  rx_if ();
  tnf_out_if res_if ();

  telnet_negotiation_filter_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .rx_chan  (rx_if),
    .res_chan (res_if)
  );

  tnf_stream_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .rx_chan      (rx_if),
    .res_chan     (res_if),
    .mismatch_cnt (mismatch_cnt),
    .expected_cnt (expected_cnt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_random_seq();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (pick < 50) begin
      send_byte(CODE_IAC);
      send_byte(CODE_IAC);
    end else if (pick < 75) begin
      send_byte(CODE_IAC);
      send_byte(CODE_WILL + 8'($urandom_range(0, 3)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      send_byte(CODE_IAC);
      send_byte(CODE_SB);
      len = $urandom_range(0, 6);
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) send_byte(CODE_IAC);
        else send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(CODE_IAC);
      send_byte(CODE_SE);
    end else if (pick < 93) begin
      send_byte(CODE_IAC);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst              = 1'b1;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    res_if.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_byte(8'h00);
    send_byte(CODE_IAC);
    send_byte(CODE_IAC);
    send_byte(CODE_SE);
    send_byte(CODE_IAC);
    send_byte(CODE_DO);
    send_byte(8'h00);
    send_byte(CODE_IAC);
    send_byte(CODE_DONT);
    send_byte(CODE_IAC);
    send_byte(CODE_IAC);
    send_byte(CODE_WILL);
    send_byte(8'h18);
    send_byte(CODE_IAC);
    send_byte(CODE_WONT);
    send_byte(8'h01);
    // subnegotiation with an IAC run and a stray IAC pair
    send_byte(CODE_IAC);
    send_byte(CODE_SB);
    send_byte(CODE_IAC);
    send_byte(CODE_IAC);
    send_byte(8'h05);
    send_byte(CODE_IAC);
    send_byte(CODE_SE);
    // unknown command
    send_byte(CODE_IAC);
    send_byte(8'hF1);

    while (sent_cnt < NUM_REQUESTS) begin
      if (sent_cnt >= QUIET_FROM) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent_cnt % 100 < 3) begin
        tx_idle_pct = 10 * $urandom_range(0, 4);
        rx_idle_pct = 10 * $urandom_range(0, 4);
      end
      send_random_seq();
    end
    rx_if.valid <= 1'b0;

    @(posedge clk);
    while (expected_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cnt != 0) $error("%0d expected results never arrived", expected_cnt);
    if (mismatch_cnt == 0 && expected_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
